>>> design/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst is high.
`define AST_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication check failed");

// Next-cycle implication, sampled on clk, off while rst is high.
`define AST_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

>>> design/aet_pkg.sv
package aet_pkg;

  typedef logic signed [31:0] word_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_M00 = 3'd0,
    REG_M01 = 3'd1,
    REG_TX  = 3'd2,
    REG_M10 = 3'd3,
    REG_M11 = 3'd4,
    REG_TY  = 3'd5
  } reg_idx_t;

  // Inverse of the linear part, [[p, q], [r, s]] in Q8.24
  typedef struct packed {
    word_t p;
    word_t q;
    word_t r;
    word_t s;
    logic  invalid;
  } inv_t;

  typedef struct packed {
    word_t value;
    logic  clipped;
  } sat_t;

  localparam word_t ONE_Q24 = 32'sd16777216;
  localparam logic signed [63:0] RND_HALF = 64'sd8388608;
  localparam logic signed [63:0] WORD_MAX = 64'sd2147483647;
  localparam logic signed [63:0] WORD_MIN = -64'sd2147483648;

  // Clip a wide signed value to 32 bits and flag the clip
  function automatic sat_t sat_word(input logic signed [63:0] v);
    sat_t res;
    res.clipped = 1'b0;
    if (v > WORD_MAX) begin
      res.value   = 32'sh7fffffff;
      res.clipped = 1'b1;
    end else if (v < WORD_MIN) begin
      res.value   = 32'sh80000000;
      res.clipped = 1'b1;
    end else begin
      res.value = v[31:0];
    end
    return res;
  endfunction

endpackage

>>> design/affine_ellipse_transform.sv
// Affine map of ellipses. One ellipse (centre plus conic coefficients a, b, c)
// is taken per cycle whenever start is high and busy is low; its result shows
// on the result ports once it leaves the pipeline, with done high for a single
// cycle. The receiver cannot stall, so every result must be captured while
// done is high. Results stream out in acceptance order, one per cycle at full
// rate, through a six-stage pipeline: two multiply stages, each followed by a
// rounding add, then saturation and the output register. A write to any of
// the six configuration registers (index 0 to 5) starts a recompute of the
// inverse linear part in a shared bit-serial restoring divider: states DET_A,
// DET_B and DET_C form the determinant, then each inverse entry passes through
// LOAD, the DIV iterations and STORE; a zero determinant skips the entries.
// During that time busy is high and cfg_ready is low. Writes to indexes 6 and
// 7 are accepted and dropped. Configure only with no ellipse in flight. With a
// singular linear part each result has singular set and all other fields zero.
module affine_ellipse_transform import aet_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  // ellipse input
  input  logic        start,
  output logic        busy,
  input  word_t       centre_x,
  input  word_t       centre_y,
  input  word_t       coef_a,
  input  word_t       coef_b,
  input  word_t       coef_c,
  // result output
  output logic        done,
  output word_t       new_x,
  output word_t       new_y,
  output word_t       new_a,
  output word_t       new_b,
  output word_t       new_c,
  output logic        singular,
  output logic        saturated,
  // configuration write channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  word_t m00, m01, tx, m10, m11, ty;

  logic  inv_busy;
  inv_t  inv;
  logic  cfg_fire;
  logic  recalc;
  logic  item_fire;

  logic  conic_valid;
  logic  conic_sing;
  word_t ca, cb, cc;
  logic  conic_clip;
  word_t cx, cy;
  logic  centre_clip;

  // Hold off both channels while the inverse is being rebuilt
  assign busy      = inv_busy;
  assign cfg_ready = !inv_busy;
  assign cfg_fire  = cfg_valid && cfg_ready;
  assign item_fire = start && !busy;

  // Only in-range writes trigger a recompute
  always_comb begin
    unique case (reg_idx_t'(cfg_index))
      REG_M00, REG_M01, REG_TX, REG_M10, REG_M11, REG_TY: recalc = cfg_fire;
      default:                                            recalc = 1'b0;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      m00 <= ONE_Q24;
      m01 <= '0;
      tx  <= '0;
      m10 <= '0;
      m11 <= ONE_Q24;
      ty  <= '0;
    end else if (cfg_fire) begin
      unique case (reg_idx_t'(cfg_index))
        REG_M00: m00 <= cfg_data;
        REG_M01: m01 <= cfg_data;
        REG_TX:  tx  <= cfg_data;
        REG_M10: m10 <= cfg_data;
        REG_M11: m11 <= cfg_data;
        REG_TY:  ty  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Inverse of the linear part, rebuilt after each in-range write
  aet_inv u_inv (
    .clk    (clk),
    .rst    (rst),
    .recalc (recalc),
    .m00    (m00),
    .m01    (m01),
    .m10    (m10),
    .m11    (m11),
    .busy   (inv_busy),
    .inv    (inv)
  );

  // Coefficient path carries the valid bits for the whole item
  aet_conic u_conic (
    .clk          (clk),
    .rst          (rst),
    .valid_in     (item_fire),
    .coef_a       (coef_a),
    .coef_b       (coef_b),
    .coef_c       (coef_c),
    .inv          (inv),
    .valid_out    (conic_valid),
    .singular_out (conic_sing),
    .new_a        (ca),
    .new_b        (cb),
    .new_c        (cc),
    .clipped      (conic_clip)
  );

  // Centre path runs in lockstep with the coefficient path
  aet_centre u_centre (
    .clk     (clk),
    .x       (centre_x),
    .y       (centre_y),
    .m00     (m00),
    .m01     (m01),
    .m10     (m10),
    .m11     (m11),
    .tx      (tx),
    .ty      (ty),
    .new_x   (cx),
    .new_y   (cy),
    .clipped (centre_clip)
  );

  // Output register: zero everything but the flag for a singular map
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= conic_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (conic_valid) begin
      new_x     <= conic_sing ? '0 : cx;
      new_y     <= conic_sing ? '0 : cy;
      new_a     <= conic_sing ? '0 : ca;
      new_b     <= conic_sing ? '0 : cb;
      new_c     <= conic_sing ? '0 : cc;
      singular  <= conic_sing;
      saturated <= !conic_sing && (conic_clip || centre_clip);
    end
  end

endmodule

>>> design/aet_inv.sv
module aet_inv import aet_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  recalc,
  input  word_t m00,
  input  word_t m01,
  input  word_t m10,
  input  word_t m11,
  output logic  busy,
  output inv_t  inv
);

  localparam int ITER  = 80;
  localparam int FRAC  = 48;
  localparam int CNT_W = $clog2(ITER);
  localparam logic [40:0] QCAP = 41'h100_0000_0000;

  typedef enum logic [2:0] {IDLE, DET_A, DET_B, DET_C, LOAD, DIV, STORE} state_t;

  state_t              state;
  logic signed [63:0]  prod_a;
  logic signed [63:0]  prod_b;
  logic [62:0]         dmag;
  logic                dneg;
  logic [1:0]          slot;
  logic [31:0]         num;
  logic                qneg;
  logic [62:0]         rem;
  logic [40:0]         quo;
  logic [CNT_W-1:0]    cnt;

  word_t               nval;
  logic                negate;
  logic [31:0]         nmag;
  logic                in_bit;
  logic [63:0]         rs;
  logic [63:0]         rem_sub;
  logic                ge;
  logic [62:0]         rem_next;
  logic [41:0]         qs;
  logic [40:0]         quo_next;
  logic signed [64:0]  diff_ab;
  logic signed [64:0]  diff_ba;
  word_t               qval;

  // Numerator of each inverse entry: p = m11, q = -m01, r = -m10, s = m00
  always_comb begin
    unique case (slot)
      2'd0: begin nval = m11; negate = 1'b0; end
      2'd1: begin nval = m01; negate = 1'b1; end
      2'd2: begin nval = m10; negate = 1'b1; end
      2'd3: begin nval = m00; negate = 1'b0; end
    endcase
  end

  assign nmag = nval[31] ? (~nval + 32'd1) : nval;

  assign diff_ab = 65'(prod_a) - 65'(prod_b);
  assign diff_ba = 65'(prod_b) - 65'(prod_a);

  // One restoring step; quotient held at the cap once it passes it
  assign in_bit   = (cnt >= CNT_W'(FRAC)) ? num[31] : 1'b0;
  assign rs       = {rem, in_bit};
  assign rem_sub  = rs - {1'b0, dmag};
  assign ge       = (rs >= {1'b0, dmag});
  assign rem_next = ge ? rem_sub[62:0] : rs[62:0];
  assign qs       = {quo, ge};
  assign quo_next = (qs > {1'b0, QCAP}) ? QCAP : qs[40:0];

  always_comb begin
    if (qneg) begin
      qval = (quo > 41'd2147483648) ? 32'sh80000000 : (~quo[31:0] + 32'd1);
    end else begin
      qval = (quo > 41'd2147483647) ? 32'sh7fffffff : quo[31:0];
    end
  end

  assign busy = (state != IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      inv.p       <= ONE_Q24;
      inv.q       <= '0;
      inv.r       <= '0;
      inv.s       <= ONE_Q24;
      inv.invalid <= 1'b0;
    end else begin
      unique case (state)
        IDLE: begin
          if (recalc) state <= DET_A;
        end
        DET_A: begin
          prod_a <= 64'(m00) * 64'(m11);
          state  <= DET_B;
        end
        DET_B: begin
          prod_b <= 64'(m01) * 64'(m10);
          state  <= DET_C;
        end
        DET_C: begin
          dneg <= (prod_a < prod_b);
          dmag <= (prod_a < prod_b) ? diff_ba[62:0] : diff_ab[62:0];
          slot <= 2'd0;
          if (prod_a == prod_b) begin
            inv.p       <= '0;
            inv.q       <= '0;
            inv.r       <= '0;
            inv.s       <= '0;
            inv.invalid <= 1'b1;
            state       <= IDLE;
          end else begin
            inv.invalid <= 1'b0;
            state       <= LOAD;
          end
        end
        LOAD: begin
          num   <= nmag;
          qneg  <= (negate ? (!nval[31] && (nval != '0)) : nval[31]) ^ dneg;
          rem   <= '0;
          quo   <= '0;
          cnt   <= CNT_W'(ITER - 1);
          state <= DIV;
        end
        DIV: begin
          if (cnt >= CNT_W'(FRAC)) num <= {num[30:0], 1'b0};
          rem <= rem_next;
          quo <= quo_next;
          if (cnt == '0) begin
            state <= STORE;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        STORE: begin
          unique case (slot)
            2'd0: inv.p <= qval;
            2'd1: inv.q <= qval;
            2'd2: inv.r <= qval;
            2'd3: inv.s <= qval;
          endcase
          if (slot == 2'd3) begin
            state <= IDLE;
          end else begin
            slot  <= slot + 2'd1;
            state <= LOAD;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

>>> design/aet_centre.sv
module aet_centre import aet_pkg::*; (
  input  logic  clk,
  input  word_t x,
  input  word_t y,
  input  word_t m00,
  input  word_t m01,
  input  word_t m10,
  input  word_t m11,
  input  word_t tx,
  input  word_t ty,
  output word_t new_x,
  output word_t new_y,
  output logic  clipped
);

  logic signed [63:0] px0, py0, px1, py1;
  logic signed [40:0] dx, dy;
  logic signed [41:0] ox, oy;
  word_t              rx, ry;
  logic               clip4;

  logic signed [64:0] sum_x, sum_y;
  sat_t               sat_x, sat_y;

  assign sum_x = 65'(px0) + 65'(py0) + 65'(RND_HALF);
  assign sum_y = 65'(px1) + 65'(py1) + 65'(RND_HALF);
  assign sat_x = sat_word(64'(ox));
  assign sat_y = sat_word(64'(oy));

  // Five stages to line up with the conic path
  always_ff @(posedge clk) begin
    px0   <= 64'(m00) * 64'(x);
    py0   <= 64'(m01) * 64'(y);
    px1   <= 64'(m10) * 64'(x);
    py1   <= 64'(m11) * 64'(y);
    dx    <= sum_x[64:24];
    dy    <= sum_y[64:24];
    ox    <= 42'(dx) + 42'(tx);
    oy    <= 42'(dy) + 42'(ty);
    rx    <= sat_x.value;
    ry    <= sat_y.value;
    clip4 <= sat_x.clipped | sat_y.clipped;
    new_x   <= rx;
    new_y   <= ry;
    clipped <= clip4;
  end

endmodule

>>> design/aet_conic.sv
module aet_conic import aet_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  valid_in,
  input  word_t coef_a,
  input  word_t coef_b,
  input  word_t coef_c,
  input  inv_t  inv,
  output logic  valid_out,
  output logic  singular_out,
  output word_t new_a,
  output word_t new_b,
  output word_t new_c,
  output logic  clipped
);

  word_t p, q, r, s;
  assign p = inv.p;
  assign q = inv.q;
  assign r = inv.r;
  assign s = inv.s;

  logic [3:0] vld;
  logic [3:0] sing;

  // Stage 1: first products
  logic signed [63:0] pa, rb, pb, rc, qa, sb, qb, sc;
  // Stage 2: rounded intermediate terms
  logic signed [40:0] t00, t10, t01, t11;
  // Stage 3: second products, split into high and low halves of t
  logic signed [48:0] a_ph, a_rh, b_ph, b_rh, c_qh, c_sh;
  logic signed [56:0] a_pl, a_rl, b_pl, b_rl, c_ql, c_sl;
  // Stage 4: partial sums
  logic signed [49:0] a_hi, b_hi, c_hi;
  logic signed [33:0] a_lo, b_lo, c_lo;

  logic signed [64:0] s00, s10, s01, s11;
  logic signed [16:0] t00h, t10h, t01h, t11h;
  logic signed [24:0] t00l, t10l, t01l, t11l;
  logic signed [57:0] a_lsum, b_lsum, c_lsum;
  logic signed [50:0] a_sum, b_sum, c_sum;
  sat_t               sat_a, sat_b, sat_c;

  assign s00 = 65'(pa) + 65'(rb) + 65'(RND_HALF);
  assign s10 = 65'(pb) + 65'(rc) + 65'(RND_HALF);
  assign s01 = 65'(qa) + 65'(sb) + 65'(RND_HALF);
  assign s11 = 65'(qb) + 65'(sc) + 65'(RND_HALF);

  assign t00h = t00[40:24];
  assign t10h = t10[40:24];
  assign t01h = t01[40:24];
  assign t11h = t11[40:24];
  assign t00l = {1'b0, t00[23:0]};
  assign t10l = {1'b0, t10[23:0]};
  assign t01l = {1'b0, t01[23:0]};
  assign t11l = {1'b0, t11[23:0]};

  assign a_lsum = 58'(a_pl) + 58'(a_rl) + 58'(RND_HALF);
  assign b_lsum = 58'(b_pl) + 58'(b_rl) + 58'(RND_HALF);
  assign c_lsum = 58'(c_ql) + 58'(c_sl) + 58'(RND_HALF);

  assign a_sum = 51'(a_hi) + 51'(a_lo);
  assign b_sum = 51'(b_hi) + 51'(b_lo);
  assign c_sum = 51'(c_hi) + 51'(c_lo);
  assign sat_a = sat_word(64'(a_sum));
  assign sat_b = sat_word(64'(b_sum));
  assign sat_c = sat_word(64'(c_sum));

  always_ff @(posedge clk) begin
    if (rst) begin
      vld       <= '0;
      valid_out <= 1'b0;
    end else begin
      vld       <= {vld[2:0], valid_in};
      valid_out <= vld[3];
    end
  end

  always_ff @(posedge clk) begin
    sing <= {sing[2:0], inv.invalid};

    pa <= 64'(p) * 64'(coef_a);
    rb <= 64'(r) * 64'(coef_b);
    pb <= 64'(p) * 64'(coef_b);
    rc <= 64'(r) * 64'(coef_c);
    qa <= 64'(q) * 64'(coef_a);
    sb <= 64'(s) * 64'(coef_b);
    qb <= 64'(q) * 64'(coef_b);
    sc <= 64'(s) * 64'(coef_c);

    t00 <= s00[64:24];
    t10 <= s10[64:24];
    t01 <= s01[64:24];
    t11 <= s11[64:24];

    a_ph <= 49'(p) * 49'(t00h);
    a_rh <= 49'(r) * 49'(t10h);
    a_pl <= 57'(p) * 57'(t00l);
    a_rl <= 57'(r) * 57'(t10l);
    b_ph <= 49'(p) * 49'(t01h);
    b_rh <= 49'(r) * 49'(t11h);
    b_pl <= 57'(p) * 57'(t01l);
    b_rl <= 57'(r) * 57'(t11l);
    c_qh <= 49'(q) * 49'(t01h);
    c_sh <= 49'(s) * 49'(t11h);
    c_ql <= 57'(q) * 57'(t01l);
    c_sl <= 57'(s) * 57'(t11l);

    a_hi <= 50'(a_ph) + 50'(a_rh);
    b_hi <= 50'(b_ph) + 50'(b_rh);
    c_hi <= 50'(c_qh) + 50'(c_sh);
    a_lo <= a_lsum[57:24];
    b_lo <= b_lsum[57:24];
    c_lo <= c_lsum[57:24];

    new_a        <= sat_a.value;
    new_b        <= sat_b.value;
    new_c        <= sat_c.value;
    clipped      <= sat_a.clipped | sat_b.clipped | sat_c.clipped;
    singular_out <= sing[3];
  end

endmodule

>>> design/aet_checker.sv
`include "assert_macros.svh"

module aet_checker import aet_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input word_t       new_x,
  input word_t       new_y,
  input word_t       new_a,
  input word_t       new_b,
  input word_t       new_c,
  input logic        singular,
  input logic        saturated,
  input logic        cfg_valid,
  input logic        cfg_ready,
  input logic [2:0]  cfg_index
);

  logic fields_zero;

  assign fields_zero = (new_x == '0) && (new_y == '0) && (new_a == '0) &&
                       (new_b == '0) && (new_c == '0) && !saturated;

  // Every accepted ellipse comes out after the fixed latency
  `AST_IMP(a_latency, start && !busy, ##6 done)

  // No result without an earlier accepted ellipse
  `AST_IMP(a_no_orphan, done, $past(start && !busy, 6))

  // A singular map zeroes every field but its flag
  `AST_IMP(a_singular_zero, done && singular, fields_zero)

  // An in-range register write starts the inverse rebuild
  `AST_NEXT(a_recalc_busy, cfg_valid && cfg_ready && cfg_index <= 3'(REG_TY), busy && !cfg_ready)

endmodule

bind affine_ellipse_transform aet_checker u_aet_checker (.*);

>>> test/tb_top.sv
module tb_top;
  import aet_pkg::*;

  // Wide signed scratch type: products of a Q8.24 entry with a Q17.24 term
  // and the 2^48-scaled division numerators all fit with room to spare.
  typedef logic signed [127:0] wide_t;

  // What the host does next: send one ellipse, write one register, or hold
  // until every ellipse in flight has come back.
  typedef enum logic [1:0] {
    OP_ELLIPSE,
    OP_WRITE,
    OP_SETTLE
  } host_op_kind_t;

  typedef struct packed {
    host_op_kind_t kind;
    logic [2:0]    gap;
    logic [2:0]    idx;
    logic [31:0]   data;
    word_t         x;
    word_t         y;
    word_t         a;
    word_t         b;
    word_t         c;
  } host_op_t;

  typedef struct packed {
    word_t new_x;
    word_t new_y;
    word_t new_a;
    word_t new_b;
    word_t new_c;
    logic  singular;
    logic  saturated;
  } ellipse_out_t;

  localparam int unsigned CYCLE_LIMIT  = 400000;
  localparam int unsigned DRAIN_CYCLES = 20;
  localparam int unsigned Q24_BITS     = 24;
  localparam int unsigned INV_SHIFT    = 48;
  localparam wide_t       ROUND_HALF   = 128'sd8388608;
  localparam word_t       FULL_POS     = 32'sh7fffffff;
  localparam word_t       FULL_NEG     = 32'sh80000000;
  // Indexes past the last register: the block takes the transfer and drops it
  localparam logic [2:0]  REG_SPARE_LO = 3'd6;
  localparam logic [2:0]  REG_SPARE_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        start = 1'b0;
  logic        busy;
  word_t       centre_x = '0;
  word_t       centre_y = '0;
  word_t       coef_a = '0;
  word_t       coef_b = '0;
  word_t       coef_c = '0;
  logic        done;
  word_t       new_x;
  word_t       new_y;
  word_t       new_a;
  word_t       new_b;
  word_t       new_c;
  logic        singular;
  logic        saturated;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;

  affine_ellipse_transform dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .centre_x  (centre_x),
    .centre_y  (centre_y),
    .coef_a    (coef_a),
    .coef_b    (coef_b),
    .coef_c    (coef_c),
    .done      (done),
    .new_x     (new_x),
    .new_y     (new_y),
    .new_a     (new_a),
    .new_b     (new_b),
    .new_c     (new_c),
    .singular  (singular),
    .saturated (saturated),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Mirror of the block's register file and of the inverse it derives.
  // Reset values: identity map, no translation, inverse valid.
  word_t map_reg [6] = '{ONE_Q24, '0, '0, '0, ONE_Q24, '0};
  word_t inv_p = ONE_Q24;
  word_t inv_q = '0;
  word_t inv_r = '0;
  word_t inv_s = ONE_Q24;
  logic  inv_bad = 1'b0;

  host_op_t     host_ops [$];   // stimulus not yet handed to the block
  ellipse_out_t awaited [$];    // predicted results, oldest first

  logic        ellipse_taken = 1'b0;
  logic        cfg_taken = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned gap_ceiling = 4;
  int unsigned fault_count = 0;
  int unsigned cycle_count = 0;

  // Clip to 32 bits signed; raise hit when clipped.
  function automatic word_t clip_word(wide_t v, inout logic hit);
    if (v > WORD_MAX) begin
      hit = 1'b1;
      v = WORD_MAX;
    end else if (v < WORD_MIN) begin
      hit = 1'b1;
      v = WORD_MIN;
    end
    return v[31:0];
  endfunction

  // Exact u0*v0 + u1*v1, scaled down by 2^24, halves rounded up.
  function automatic wide_t dot_q24(wide_t u0, wide_t v0, wide_t u1, wide_t v1);
    return (u0 * v0 + u1 * v1 + ROUND_HALF) >>> Q24_BITS;
  endfunction

  // One inverse entry: numer * 2^48 / det, truncated toward zero. Its clip
  // is internal and never reaches the saturated flag.
  function automatic word_t inverse_entry(wide_t numer, wide_t det);
    logic ignored;
    ignored = 1'b0;
    return clip_word((numer <<< INV_SHIFT) / det, ignored);
  endfunction

  // Apply one in-range register transfer and redo the linear part's inverse.
  function automatic void load_register(logic [2:0] idx, logic [31:0] data);
    wide_t m00;
    wide_t m01;
    wide_t m10;
    wide_t m11;
    wide_t det;
    if (idx > REG_TY) return;
    map_reg[idx] = data;
    m00 = map_reg[REG_M00];
    m01 = map_reg[REG_M01];
    m10 = map_reg[REG_M10];
    m11 = map_reg[REG_M11];
    det = m00 * m11 - m01 * m10;
    inv_bad = (det == 0);
    if (inv_bad) begin
      inv_p = '0;
      inv_q = '0;
      inv_r = '0;
      inv_s = '0;
    end else begin
      inv_p = inverse_entry(m11, det);
      inv_q = inverse_entry(-m01, det);
      inv_r = inverse_entry(-m10, det);
      inv_s = inverse_entry(m00, det);
    end
  endfunction

  // Map one ellipse: centre through M plus translation, conic through
  // inv(M)^T C inv(M), with the intermediate products kept at full width.
  function automatic ellipse_out_t transform_ellipse(word_t x, word_t y, word_t a,
                                                     word_t b, word_t c);
    ellipse_out_t res;
    wide_t        t00;
    wide_t        t10;
    wide_t        t01;
    wide_t        t11;
    logic         clip;
    res = '0;
    clip = 1'b0;
    if (inv_bad) begin
      res.singular = 1'b1;
      return res;
    end
    res.new_x = clip_word(dot_q24(map_reg[REG_M00], x, map_reg[REG_M01], y)
                          + map_reg[REG_TX], clip);
    res.new_y = clip_word(dot_q24(map_reg[REG_M10], x, map_reg[REG_M11], y)
                          + map_reg[REG_TY], clip);
    t00 = dot_q24(inv_p, a, inv_r, b);
    t10 = dot_q24(inv_p, b, inv_r, c);
    t01 = dot_q24(inv_q, a, inv_s, b);
    t11 = dot_q24(inv_q, b, inv_s, c);
    res.new_a = clip_word(dot_q24(inv_p, t00, inv_r, t10), clip);
    res.new_b = clip_word(dot_q24(inv_p, t01, inv_r, t11), clip);
    res.new_c = clip_word(dot_q24(inv_q, t01, inv_s, t11), clip);
    res.saturated = clip;
    return res;
  endfunction

  function automatic void report_field(string name, logic signed [63:0] want,
                                       logic signed [63:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      fault_count++;
    end
  endfunction

  function automatic void queue_ellipse(word_t x, word_t y, word_t a, word_t b, word_t c);
    host_op_t op;
    op = '0;
    op.kind = OP_ELLIPSE;
    op.gap = 3'($urandom_range(0, gap_ceiling));
    op.x = x;
    op.y = y;
    op.a = a;
    op.b = b;
    op.c = c;
    host_ops.push_back(op);
  endfunction

  function automatic void queue_write(logic [2:0] idx, logic [31:0] data);
    host_op_t op;
    op = '0;
    op.kind = OP_WRITE;
    op.gap = 3'($urandom_range(0, gap_ceiling));
    op.idx = idx;
    op.data = data;
    host_ops.push_back(op);
  endfunction

  function automatic void queue_settle();
    host_op_t op;
    op = '0;
    op.kind = OP_SETTLE;
    host_ops.push_back(op);
  endfunction

  // Load a whole map; drain the pipeline first so no ellipse sees a mixed map.
  function automatic void queue_map(word_t m00, word_t m01, word_t tx,
                                    word_t m10, word_t m11, word_t ty);
    queue_settle();
    queue_write(REG_M00, m00);
    queue_write(REG_M01, m01);
    queue_write(REG_TX, tx);
    queue_write(REG_M10, m10);
    queue_write(REG_M11, m11);
    queue_write(REG_TY, ty);
  endfunction

  // Mostly values within +-2^span_bits, with a share of full-range noise and
  // of the two extremes.
  function automatic word_t pick_value(int unsigned span_bits);
    unique case ($urandom_range(0, 15))
      0: return $urandom;
      1: return FULL_POS;
      2: return FULL_NEG;
      default: return word_t'($urandom & ((32'd2 << span_bits) - 32'd1))
                      - (word_t'(1) <<< span_bits);
    endcase
  endfunction

  // Sample on the rising edge. The block's outputs still hold their pre-edge
  // values here, so the handshakes seen match what the block itself saw.
  always @(posedge clk) begin : watch
    ellipse_out_t want;
    if (rst) begin
      ellipse_taken <= 1'b0;
      cfg_taken     <= 1'b0;
    end else begin
      ellipse_taken <= start && !busy;
      cfg_taken     <= cfg_valid && cfg_ready;
      // Check the result first: it always belongs to an older ellipse.
      if (done) begin
        if (awaited.size() == 0) begin
          $error("result strobe with no ellipse outstanding");
          fault_count++;
        end else begin
          want = awaited.pop_front();
          report_field("new_x", want.new_x, new_x);
          report_field("new_y", want.new_y, new_y);
          report_field("new_a", want.new_a, new_a);
          report_field("new_b", want.new_b, new_b);
          report_field("new_c", want.new_c, new_c);
          report_field("singular", want.singular, singular);
          report_field("saturated", want.saturated, saturated);
        end
      end
      // Track the register transfer, then predict the accepted ellipse.
      if (cfg_valid && cfg_ready) load_register(cfg_index, cfg_data);
      if (start && !busy) begin
        awaited.push_back(transform_ellipse(centre_x, centre_y, coef_a, coef_b, coef_c));
      end
    end
  end

  // Drive on the falling edge. Each control signal gets exactly one
  // nonblocking write per edge, so a back-to-back transfer keeps start high.
  always @(negedge clk) begin : feed
    logic     keep_start;
    logic     keep_cfg;
    host_op_t op;
    // Hold a request until its transfer has been seen.
    keep_start = start && !ellipse_taken;
    keep_cfg   = cfg_valid && !cfg_taken;
    if (!rst && !keep_start && !keep_cfg && host_ops.size() != 0) begin
      if (hold_cycles != 0) begin
        hold_cycles--;
      end else if (host_ops[0].kind == OP_SETTLE) begin
        // Pause the sender until every outstanding result has come back.
        if (awaited.size() == 0) host_ops.delete(0);
      end else begin
        op = host_ops.pop_front();
        hold_cycles = 32'(op.gap);
        if (op.kind == OP_WRITE) begin
          keep_cfg = 1'b1;
          cfg_index <= op.idx;
          cfg_data  <= op.data;
        end else begin
          keep_start = 1'b1;
          centre_x <= op.x;
          centre_y <= op.y;
          coef_a   <= op.a;
          coef_b   <= op.b;
          coef_c   <= op.c;
        end
      end
    end
    start     <= keep_start;
    cfg_valid <= keep_cfg;
  end

  // Bound the run: every divider pass and gap of the slowest correct run
  // fits several times over.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int unsigned phase;
    int unsigned n;
    word_t       col_x;
    word_t       col_y;

    // Directed: reset map first, with extremes and alternating bit patterns
    // so that every bit of every field is seen at both values.
    gap_ceiling = 4;
    queue_ellipse('0, '0, '0, '0, '0);
    queue_ellipse(FULL_POS, FULL_POS, FULL_POS, FULL_POS, FULL_POS);
    queue_ellipse(FULL_NEG, FULL_NEG, FULL_NEG, FULL_NEG, FULL_NEG);
    queue_ellipse(32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa);
    queue_ellipse(32'sh55555555, 32'shaaaaaaaa, 32'sh55555555, 32'shaaaaaaaa, 32'sh55555555);

    // Writes past the register file must leave the map untouched.
    queue_settle();
    queue_write(REG_SPARE_LO, '0);
    queue_write(REG_SPARE_HI, '1);
    queue_ellipse(32'sd4096, -32'sd4096, ONE_Q24, '0, ONE_Q24);

    // Double scale with the translation at both extremes: centre clips.
    queue_map(2 * ONE_Q24, '0, FULL_POS, '0, 2 * ONE_Q24, FULL_NEG);
    queue_ellipse(FULL_POS, FULL_NEG, ONE_Q24, ONE_Q24 / 2, ONE_Q24);
    queue_ellipse(-32'sd4096, 32'sd4096, FULL_POS, FULL_NEG, FULL_POS);
    queue_ellipse('0, '0, '0, '0, '0);

    // One-LSB diagonal: the inverse clips internally and the conic clips.
    queue_map(32'sd1, '0, '0, '0, 32'sd1, '0);
    queue_ellipse(32'sd123, -32'sd456, ONE_Q24, '0, ONE_Q24);
    queue_ellipse('0, '0, '0, '0, '0);

    // Largest determinant magnitude the entries allow.
    queue_map(FULL_NEG, FULL_NEG, FULL_NEG, FULL_POS, FULL_NEG, FULL_POS);
    queue_ellipse(FULL_POS, FULL_POS, FULL_POS, FULL_NEG, FULL_POS);
    queue_ellipse(FULL_NEG, 32'sd1, -32'sd1, '0, 32'sd1);

    // Plain shear with a modest translation.
    queue_map(ONE_Q24, ONE_Q24 / 2, 32'sd4096, -ONE_Q24 / 4, 3 * ONE_Q24 / 2, -32'sd4096);
    queue_ellipse(32'sd8192, -32'sd8192, ONE_Q24, ONE_Q24 / 8, 2 * ONE_Q24);

    // Singular linear part: all zero, then rank one.
    queue_map('0, '0, '0, '0, '0, '0);
    queue_ellipse(FULL_POS, FULL_NEG, FULL_POS, FULL_NEG, FULL_POS);
    queue_ellipse(32'sd1, 32'sd2, 32'sd3, 32'sd4, 32'sd5);
    queue_map(ONE_Q24, ONE_Q24, 32'sd100, ONE_Q24, ONE_Q24, 32'sd100);
    queue_ellipse(32'sd4096, 32'sd4096, ONE_Q24, '0, ONE_Q24);

    // A single write takes the map out of the singular state.
    queue_settle();
    queue_write(REG_M11, 2 * ONE_Q24);
    queue_ellipse(-32'sd4096, 32'sd8192, ONE_Q24, ONE_Q24 / 4, ONE_Q24 / 2);

    // Random phases: each picks a kind of map and a pacing, then streams
    // ellipses of moderate size with some full-range noise mixed in.
    for (phase = 0; phase < 14; phase++) begin
      gap_ceiling = (phase % 3 == 0) ? 0 : 4;
      unique case (phase % 5)
        0: queue_map(pick_value(25), pick_value(25), pick_value(30),
                     pick_value(25), pick_value(25), pick_value(30));
        1: queue_map($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
        2: begin
          // Equal columns give a zero determinant for any values.
          col_x = pick_value(25);
          col_y = pick_value(25);
          queue_map(col_x, col_x, pick_value(30), col_y, col_y, pick_value(30));
        end
        3: begin
          queue_settle();
          n = $urandom_range(1, 3);
          repeat (n) queue_write(3'($urandom_range(0, 7)), pick_value(25));
        end
        default: queue_map(pick_value(26), '0, pick_value(28), '0, pick_value(26),
                           pick_value(28));
      endcase
      repeat (103) begin
        queue_ellipse(pick_value(28), pick_value(28), pick_value(26), pick_value(26),
                      pick_value(26));
        if ($urandom_range(0, 49) == 0) queue_settle();
      end
    end

    // Hold reset, then release it on a falling edge.
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Wait for the last transfer, then for every result, then let the
    // pipeline run dry to catch any stray strobe.
    while (host_ops.size() != 0 || start || cfg_valid || awaited.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (fault_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
